// ===== hw/rtl/bbm_pkg.sv =====
package bbm_pkg;

    // tag carried alongside a quotient through the divider chain
    typedef struct packed {
        logic valid;
        logic last;
    } bbm_tag_t;

    // register indexes (byte address = 4 * index)
    localparam logic CFG_IMAGE_SIZE  = 1'b0;
    localparam logic CFG_WINDOW_SIZE = 1'b1;

    localparam logic [10:0] IMAGE_SIZE_RST  = 11'd512;
    localparam logic [2:0]  WINDOW_SIZE_RST = 3'd5;

endpackage

// ===== hw/rtl/box_blur_mean_filter_core.sv =====
// Channel  | Dir | Handshake        | Payload
// s_*      | in  | s_tvalid/tready  | tdata: pixel_in; tuser: drain
// m_*      | out | m_tvalid/tready  | tdata: blurred_pixel; tlast: last_of_image
// APB      | in  | psel/penable     | reg 0 image_size @0x0, reg 1 window_size @0x4
//
// An item that yields no result is taken in ST_IDLE and the block stays there. An item that yields a result
// walks (2h+1)^2 window reads (one line-store port, one read a cycle), then goes through ST_FLUSH, ST_LAUNCH,
// the DIV_W divider cells and ST_EMIT; with h = window_size/2.
// The result sits in an output register; the next item is taken while it waits.
// Reset (async, active low) clears control state; the line store is not cleared.
// A stalled output only holds the block once the next result is ready to load.
module box_blur_mean_filter_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_WINDOW = 7,
    parameter int PIXEL_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((PIXEL_BITS+7)/8)*8-1:0]     s_tdata,   // [PIXEL_BITS-1:0] pixel_in
    input  logic                                s_tuser,   // [0] drain
    // output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((PIXEL_BITS+7)/8)*8-1:0]     m_tdata,   // [PIXEL_BITS-1:0] blurred_pixel
    output logic                                m_tlast,   // last_of_image
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bbm_pkg::*;

    localparam int TDW   = ((PIXEL_BITS+7)/8)*8;
    localparam int RING  = (MAX_WINDOW-1)*MAX_WIDTH + MAX_WINDOW;
    localparam int RW    = $clog2(RING);
    localparam int NW    = $clog2(MAX_WIDTH+1);
    localparam int HMAX  = MAX_WINDOW/2;
    localparam int HW    = $clog2(HMAX+1);
    localparam int JW    = $clog2(MAX_WINDOW);
    localparam int TW    = $clog2(MAX_WIDTH*MAX_WIDTH+1);
    localparam int IPW   = $clog2(MAX_WIDTH*MAX_WIDTH + HMAX*(MAX_WIDTH+1) + 2);
    localparam int CW    = $clog2(MAX_WINDOW*MAX_WINDOW+1);
    localparam int SW    = PIXEL_BITS + CW;
    localparam int DIV_W = SW + 1;   // dividend 2*sum+cnt
    localparam int DW    = CW + 1;   // divisor 2*cnt

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GATHER,
        ST_FLUSH,
        ST_LAUNCH,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    // ---------------- configuration ----------------
    logic [10:0] img_reg;
    logic [2:0]  win_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == CFG_WINDOW_SIZE) ? {29'd0, win_reg} : {21'd0, img_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_reg <= IMAGE_SIZE_RST;
            win_reg <= WINDOW_SIZE_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == CFG_WINDOW_SIZE)
            begin
                win_reg <= pwdata[2:0];
            end
            else
            begin
                img_reg <= pwdata[10:0];
            end
        end
    end

    // effective side, half window, pixel count and input lead (in pixels) before the first output
    logic [NW-1:0] n_eff;
    logic [HW-1:0] h_eff;
    logic [JW-1:0] two_h;
    logic [TW-1:0] total;
    int            lat_i;

    always_comb
    begin
        if (img_reg == 11'd0)
            n_eff = NW'(1);
        else if (int'(img_reg) > MAX_WIDTH)
            n_eff = NW'(MAX_WIDTH);
        else
            n_eff = NW'(img_reg);
        if (int'(win_reg[2:1]) > HMAX)
            h_eff = HW'(HMAX);
        else
            h_eff = HW'(win_reg[2:1]);
        two_h = JW'(2 * int'(h_eff));
        total = TW'(int'(n_eff) * int'(n_eff));
        lat_i = int'(h_eff) * int'(n_eff) + int'(h_eff);
    end

    function automatic logic [RW-1:0] ring_add(input logic [RW-1:0] a, input logic [RW:0] b);
        logic [RW:0] s;
        s = {1'b0, a} + b;
        if (int'(s) >= RING)
            s = s - (RW+1)'(RING);
        return s[RW-1:0];
    endfunction

    // ---------------- control ----------------
    state_t              state_reg, state_next;
    logic [IPW-1:0]      ipos_reg, ipos_next;
    logic [TW-1:0]       opos_reg, opos_next;
    logic [NW-1:0]       orow_reg, orow_next;
    logic [NW-1:0]       ocol_reg, ocol_next;
    logic [RW-1:0]       wptr_reg, wptr_next;
    logic [RW-1:0]       optr_reg, optr_next;
    // window walk
    logic [NW-1:0]       grow_reg, grow_next;
    logic [NW-1:0]       gcol_reg, gcol_next;
    logic [JW-1:0]       gi_reg, gi_next;
    logic [JW-1:0]       gj_reg, gj_next;
    logic [RW-1:0]       rowaddr_reg, rowaddr_next;
    logic                glast_reg, glast_next;
    logic                rdpend_reg, rdpend_next;
    logic [SW-1:0]       sum_reg, sum_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [PIXEL_BITS-1:0] q_reg, q_next;
    logic                qlast_reg, qlast_next;
    // output register
    logic                mvalid_reg, mvalid_next;
    logic [PIXEL_BITS-1:0] mdata_reg, mdata_next;
    logic                mlast_reg, mlast_next;

    logic                in_acc;
    logic                mem_we;
    logic [RW-1:0]       rd_addr;
    logic [PIXEL_BITS-1:0] rd_data_reg;
    logic                win_ok;
    int                  r_i, c_i;

    // divider chain ends
    bbm_tag_t            div_tag_in;
    logic [DIV_W-1:0]    div_num_in;
    logic [DW-1:0]       div_den_in;
    bbm_tag_t            div_tag_out;
    logic [DIV_W-1:0]    div_quot_out;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = TDW'(mdata_reg);
    assign m_tlast  = mlast_reg;

    always_comb
    begin
        r_i     = int'(grow_reg) + int'(gi_reg) - int'(h_eff);
        c_i     = int'(gcol_reg) + int'(gj_reg) - int'(h_eff);
        win_ok  = (r_i >= 0) && (r_i < int'(n_eff)) && (c_i >= 0) && (c_i < int'(n_eff));
        rd_addr = ring_add(rowaddr_reg, (RW+1)'(gj_reg));
    end

    always_comb
    begin
        state_next   = state_reg;
        ipos_next    = ipos_reg;
        opos_next    = opos_reg;
        orow_next    = orow_reg;
        ocol_next    = ocol_reg;
        wptr_next    = wptr_reg;
        optr_next    = optr_reg;
        grow_next    = grow_reg;
        gcol_next    = gcol_reg;
        gi_next      = gi_reg;
        gj_next      = gj_reg;
        rowaddr_next = rowaddr_reg;
        glast_next   = glast_reg;
        rdpend_next  = 1'b0;
        sum_next     = sum_reg;
        cnt_next     = cnt_reg;
        q_next       = q_reg;
        qlast_next   = qlast_reg;
        mvalid_next  = mvalid_reg && !m_tready;
        mdata_next   = mdata_reg;
        mlast_next   = mlast_reg;
        mem_we       = 1'b0;
        div_tag_in   = '0;
        div_num_in   = {sum_reg, 1'b0} + DIV_W'(cnt_reg);
        div_den_in   = {cnt_reg, 1'b0};

        // finished read lands in the cycle after issue
        if (rdpend_reg)
        begin
            sum_next = sum_reg + SW'(rd_data_reg);
            cnt_next = cnt_reg + CW'(1);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    // drain before the image is complete is dropped
                    if (!(int'(ipos_reg) < int'(total) && s_tuser))
                    begin
                        if (int'(ipos_reg) < int'(total))
                        begin
                            mem_we    = 1'b1;
                            wptr_next = ring_add(wptr_reg, (RW+1)'(1));
                        end
                        ipos_next = ipos_reg + IPW'(1);
                        if (int'(ipos_reg) + 1 > lat_i)
                        begin
                            // snapshot output pixel k, then advance
                            grow_next    = orow_reg;
                            gcol_next    = ocol_reg;
                            gi_next      = '0;
                            gj_next      = '0;
                            rowaddr_next = ring_add(optr_reg, (RW+1)'(RING - lat_i));
                            glast_next   = (int'(opos_reg) + 1 == int'(total));
                            sum_next     = '0;
                            cnt_next     = '0;
                            state_next   = ST_GATHER;
                            if (int'(opos_reg) + 1 >= int'(total))
                            begin
                                opos_next = '0;
                                ipos_next = '0;
                                orow_next = '0;
                                ocol_next = '0;
                                optr_next = '0;
                                wptr_next = '0;
                            end
                            else
                            begin
                                opos_next = opos_reg + TW'(1);
                                optr_next = ring_add(optr_reg, (RW+1)'(1));
                                if (int'(ocol_reg) + 1 == int'(n_eff))
                                begin
                                    ocol_next = '0;
                                    orow_next = orow_reg + NW'(1);
                                end
                                else
                                begin
                                    ocol_next = ocol_reg + NW'(1);
                                end
                            end
                        end
                    end
                end
            end
            ST_GATHER:
            begin
                rdpend_next = win_ok;
                if (gj_reg == two_h)
                begin
                    gj_next      = '0;
                    gi_next      = gi_reg + JW'(1);
                    rowaddr_next = ring_add(rowaddr_reg, (RW+1)'(n_eff));
                    if (gi_reg == two_h)
                        state_next = ST_FLUSH;
                end
                else
                begin
                    gj_next = gj_reg + JW'(1);
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_LAUNCH;
            end
            ST_LAUNCH:
            begin
                div_tag_in.valid = 1'b1;
                div_tag_in.last  = glast_reg;
                state_next       = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_tag_out.valid)
                begin
                    q_next     = div_quot_out[PIXEL_BITS-1:0];
                    qlast_next = div_tag_out.last;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = q_reg;
                    mlast_next  = qlast_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // register write restarts the image
        if (cfg_wr)
        begin
            ipos_next = '0;
            opos_next = '0;
            orow_next = '0;
            ocol_next = '0;
            optr_next = '0;
            wptr_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ipos_reg   <= '0;
            opos_reg   <= '0;
            orow_reg   <= '0;
            ocol_reg   <= '0;
            wptr_reg   <= '0;
            optr_reg   <= '0;
            rdpend_reg <= 1'b0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ipos_reg   <= ipos_next;
            opos_reg   <= opos_next;
            orow_reg   <= orow_next;
            ocol_reg   <= ocol_next;
            wptr_reg   <= wptr_next;
            optr_reg   <= optr_next;
            rdpend_reg <= rdpend_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grow_reg    <= grow_next;
        gcol_reg    <= gcol_next;
        gi_reg      <= gi_next;
        gj_reg      <= gj_next;
        rowaddr_reg <= rowaddr_next;
        glast_reg   <= glast_next;
        sum_reg     <= sum_next;
        cnt_reg     <= cnt_next;
        q_reg       <= q_next;
        qlast_reg   <= qlast_next;
        mdata_reg   <= mdata_next;
        mlast_reg   <= mlast_next;
    end

    // ---------------- line store ----------------
    logic [PIXEL_BITS-1:0] line_mem [RING];

    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[wptr_reg] <= s_tdata[PIXEL_BITS-1:0];
        rd_data_reg <= line_mem[rd_addr];
    end

    // ---------------- divider chain: one quotient bit per cell ----------------
    bbm_tag_t         tag_w  [DIV_W+1];
    logic [DW-1:0]    rem_w  [DIV_W+1];
    logic [DIV_W-1:0] num_w  [DIV_W+1];
    logic [DW-1:0]    den_w  [DIV_W+1];
    logic [DIV_W-1:0] quot_w [DIV_W+1];

    assign tag_w[0]     = div_tag_in;
    assign rem_w[0]     = '0;
    assign num_w[0]     = div_num_in;
    assign den_w[0]     = div_den_in;
    assign quot_w[0]    = '0;
    assign div_tag_out  = tag_w[DIV_W];
    assign div_quot_out = quot_w[DIV_W];

    for (genvar g = 0; g < DIV_W; g++)
    begin : g_div
        bbm_div_cell #(
            .W  (DIV_W),
            .DW (DW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .tag_in   (tag_w[g]),
            .rem_in   (rem_w[g]),
            .num_in   (num_w[g]),
            .den_in   (den_w[g]),
            .quot_in  (quot_w[g]),
            .tag_out  (tag_w[g+1]),
            .rem_out  (rem_w[g+1]),
            .num_out  (num_w[g+1]),
            .den_out  (den_w[g+1]),
            .quot_out (quot_w[g+1])
        );
    end

    // ---------------- assertions ----------------
    a_div_only_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_tag_out.valid |-> state_reg == ST_DIVIDE)
        else $error("divider result outside divide state");

    a_nonzero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LAUNCH |-> cnt_reg != '0)
        else $error("empty window launched");

    a_opos_in_image: assert property (@(posedge clk) disable iff (!rst_n)
        int'(opos_reg) < int'(total))
        else $error("output position past image");

endmodule

// ===== hw/rtl/bbm_div_cell.sv =====
module bbm_div_cell #(
    parameter int W  = 23,
    parameter int DW = 7
) (
    input  logic              clk,
    input  logic              rst_n,
    input  bbm_pkg::bbm_tag_t tag_in,
    input  logic [DW-1:0]     rem_in,
    input  logic [W-1:0]      num_in,
    input  logic [DW-1:0]     den_in,
    input  logic [W-1:0]      quot_in,
    output bbm_pkg::bbm_tag_t tag_out,
    output logic [DW-1:0]     rem_out,
    output logic [W-1:0]      num_out,
    output logic [DW-1:0]     den_out,
    output logic [W-1:0]      quot_out
);
    import bbm_pkg::*;

    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        fits;

    // one restoring step: bring down the next dividend bit
    always_comb
    begin
        trial = {rem_in, num_in[W-1]};
        diff  = trial - {1'b0, den_in};
        fits  = (trial >= {1'b0, den_in});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_out <= '0;
        end
        else
        begin
            tag_out <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_out  <= fits ? diff[DW-1:0] : trial[DW-1:0];
        num_out  <= {num_in[W-2:0], 1'b0};
        den_out  <= den_in;
        quot_out <= {quot_in[W-2:0], fits};
    end

endmodule
